/* rtl/core/ihex_pkg.sv */
// Shared types, character codes and the microcode table of the Intel HEX
// record encoder. This package has no dependencies.
package ihex_pkg;

   localparam int STEP_W = 4;
   typedef logic [STEP_W-1:0] step_type;

   localparam logic [7:0] CHAR_COLON   = 8'h3A;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_ALPHA   = 8'h41 - 8'd10;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] BYTE_MASK    = 8'hFF;

   localparam logic CMD_DATA = 1'b0;
   localparam logic CMD_END  = 1'b1;

   localparam logic REC_DATA = 1'b0;
   localparam logic REC_EOF  = 1'b1;

   typedef enum logic [1:0] {
      CHR_COLON,
      CHR_HI,
      CHR_LO,
      CHR_NEWLINE
   } chr_sel_type;

   typedef enum logic [2:0] {
      BYTE_COUNT,
      BYTE_ADDR_HI,
      BYTE_ADDR_LO,
      BYTE_REC_TYPE,
      BYTE_DATA,
      BYTE_CSUM
   } byte_sel_type;

   typedef enum logic [1:0] {
      JMP_NEXT,
      JMP_IF_EMPTY,
      JMP_IF_MORE,
      JMP_END
   } jump_type;

   typedef struct packed {
      chr_sel_type  chr_sel;
      byte_sel_type byte_sel;
      jump_type     jump;
      logic         sum_clr;
      logic         sum_add;
      logic         idx_inc;
      step_type     target;
   } ctrl_word_type;

   localparam step_type STEP_DATA_HI = 4'd9;
   localparam step_type STEP_CSUM_HI = 4'd11;
   localparam step_type STEP_LAST    = 4'd13;

   // One control word per output character of a record.
   function automatic ctrl_word_type ctrl_rom(input step_type step);
      ctrl_word_type cw;
      cw = '{CHR_NEWLINE, BYTE_CSUM, JMP_END, 1'b0, 1'b0, 1'b0, 4'd0};
      case (step)
         4'd0:  cw = '{CHR_COLON, BYTE_COUNT, JMP_NEXT, 1'b1, 1'b0, 1'b0, 4'd0};
         4'd1:  cw = '{CHR_HI, BYTE_COUNT, JMP_NEXT, 1'b0, 1'b0, 1'b0, 4'd0};
         4'd2:  cw = '{CHR_LO, BYTE_COUNT, JMP_NEXT, 1'b0, 1'b1, 1'b0, 4'd0};
         4'd3:  cw = '{CHR_HI, BYTE_ADDR_HI, JMP_NEXT, 1'b0, 1'b0, 1'b0, 4'd0};
         4'd4:  cw = '{CHR_LO, BYTE_ADDR_HI, JMP_NEXT, 1'b0, 1'b1, 1'b0, 4'd0};
         4'd5:  cw = '{CHR_HI, BYTE_ADDR_LO, JMP_NEXT, 1'b0, 1'b0, 1'b0, 4'd0};
         4'd6:  cw = '{CHR_LO, BYTE_ADDR_LO, JMP_NEXT, 1'b0, 1'b1, 1'b0, 4'd0};
         4'd7:  cw = '{CHR_HI, BYTE_REC_TYPE, JMP_NEXT, 1'b0, 1'b0, 1'b0, 4'd0};
         4'd8:  cw = '{CHR_LO, BYTE_REC_TYPE, JMP_IF_EMPTY, 1'b0, 1'b1, 1'b0,
                      STEP_CSUM_HI};
         4'd9:  cw = '{CHR_HI, BYTE_DATA, JMP_NEXT, 1'b0, 1'b0, 1'b0, 4'd0};
         4'd10: cw = '{CHR_LO, BYTE_DATA, JMP_IF_MORE, 1'b0, 1'b1, 1'b1,
                      STEP_DATA_HI};
         4'd11: cw = '{CHR_HI, BYTE_CSUM, JMP_NEXT, 1'b0, 1'b0, 1'b0, 4'd0};
         4'd12: cw = '{CHR_LO, BYTE_CSUM, JMP_NEXT, 1'b0, 1'b0, 1'b0, 4'd0};
         4'd13: cw = '{CHR_NEWLINE, BYTE_CSUM, JMP_END, 1'b0, 1'b0, 1'b0, 4'd0};
         default: cw = '{CHR_NEWLINE, BYTE_CSUM, JMP_END, 1'b0, 1'b0, 1'b0, 4'd0};
      endcase
      return cw;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] wide;
      wide = {4'd0, nib};
      return (nib < 4'd10) ? (CHAR_ZERO + wide) : (CHAR_ALPHA + wide);
   endfunction

endpackage

/* rtl/core/intel_hex_record_encoder.sv */
// Intel HEX record encoder: top level with the microcode sequencer, the
// record buffer memory and the character output register. Uses ihex_pkg.
//
// Data items that extend the buffered run are stored and give no output. An
// item that closes a record (address break, full buffer, or end command)
// keeps req_stall high while the record text streams out one character per
// cycle from the output register, as long as rsp_stall does not hold the
// output: the buffered data record, then the end-of-file record on an end
// command (only the end-of-file record if no bytes are buffered). A 14-step
// control program walks the record fields, with a loop over the buffer
// memory's single read port for the data bytes.
module intel_hex_record_encoder #(
   parameter int MAX_RECORD_BYTES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_character,
   output logic        rsp_last,
   input  logic        csr_write_enable,
   input  logic [4:0]  csr_record_length
);

   localparam int CW = $clog2(MAX_RECORD_BYTES + 1);
   localparam int AW = (MAX_RECORD_BYTES > 1) ? $clog2(MAX_RECORD_BYTES) : 1;
   localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_RECORD_BYTES);
   localparam logic [CW-1:0] ONE_COUNT = CW'(1);

   logic [7:0] record_buffer [MAX_RECORD_BYTES];

   logic [4:0]          length_ff;
   logic [CW-1:0]       count_ff, count_in;
   logic [15:0]         addr_ff, addr_in;
   logic                busy_ff, busy_in;
   ihex_pkg::step_type  step_ff, step_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic [7:0]          sum_ff, sum_in;
   logic                type_ff, type_in;
   logic                cmd_ff, cmd_in;
   logic [15:0]         item_addr_ff, item_addr_in;
   logic [7:0]          item_data_ff, item_data_in;
   logic [7:0]          rd_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_char_ff, rsp_char_in;
   logic                rsp_last_ff, rsp_last_in;

   ihex_pkg::ctrl_word_type cw;
   logic [CW-1:0] eff_len;
   logic [CW-1:0] idx_nxt;
   logic [7:0]    byte_val;
   logic [7:0]    char_val;
   logic          fire;
   logic          accept;
   logic          run_break;
   logic          run_full;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;

   assign req_stall     = busy_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

   always_comb begin
      if (length_ff == 5'd0) begin
         eff_len = ONE_COUNT;
      end else if (int'(length_ff) > MAX_RECORD_BYTES) begin
         eff_len = MAX_COUNT;
      end else begin
         eff_len = CW'(length_ff);
      end
   end

   always_comb begin
      cw      = ihex_pkg::ctrl_rom(step_ff);
      idx_nxt = idx_ff + ONE_COUNT;

      case (cw.byte_sel)
         ihex_pkg::BYTE_COUNT:    byte_val = 8'(count_ff);
         ihex_pkg::BYTE_ADDR_HI:  byte_val = addr_ff[15:8];
         ihex_pkg::BYTE_ADDR_LO:  byte_val = addr_ff[7:0];
         ihex_pkg::BYTE_REC_TYPE: byte_val = {7'd0, type_ff};
         ihex_pkg::BYTE_DATA:     byte_val = rd_ff;
         ihex_pkg::BYTE_CSUM:     byte_val = (ihex_pkg::BYTE_MASK - sum_ff) + 8'd1;
         default:                 byte_val = 8'd0;
      endcase

      case (cw.chr_sel)
         ihex_pkg::CHR_COLON:   char_val = ihex_pkg::CHAR_COLON;
         ihex_pkg::CHR_HI:      char_val = ihex_pkg::hex_char(byte_val[7:4]);
         ihex_pkg::CHR_LO:      char_val = ihex_pkg::hex_char(byte_val[3:0]);
         ihex_pkg::CHR_NEWLINE: char_val = ihex_pkg::CHAR_NEWLINE;
         default:               char_val = ihex_pkg::CHAR_NEWLINE;
      endcase
   end

   always_comb begin
      fire      = busy_ff && (!rsp_valid_ff || !rsp_stall);
      accept    = req_valid && !busy_ff;
      // The run check does not wrap: a run ending at 0xFFFF breaks at 0.
      run_break = ({1'b0, addr_ff} + 17'(count_ff)) != {1'b0, req_address};
      run_full  = count_ff >= eff_len;

      count_in     = count_ff;
      addr_in      = addr_ff;
      busy_in      = busy_ff;
      step_in      = step_ff;
      idx_in       = idx_ff;
      sum_in       = sum_ff;
      type_in      = type_ff;
      cmd_in       = cmd_ff;
      item_addr_in = item_addr_ff;
      item_data_in = item_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = req_data_byte;

      if (accept) begin
         cmd_in       = req_command;
         item_addr_in = req_address;
         item_data_in = req_data_byte;
         if (req_command == ihex_pkg::CMD_DATA) begin
            if ((count_ff != '0) && (run_break || run_full)) begin
               busy_in = 1'b1;
               step_in = '0;
               type_in = ihex_pkg::REC_DATA;
            end else begin
               wr_en = 1'b1;
               if (run_break) begin
                  addr_in  = req_address;
                  wr_addr  = '0;
                  count_in = ONE_COUNT;
               end else begin
                  wr_addr  = count_ff[AW-1:0];
                  count_in = count_ff + ONE_COUNT;
               end
            end
         end else begin
            busy_in = 1'b1;
            step_in = '0;
            if (count_ff != '0) begin
               type_in = ihex_pkg::REC_DATA;
            end else begin
               type_in  = ihex_pkg::REC_EOF;
               addr_in  = req_address;
            end
         end
      end

      if (fire) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = char_val;
         rsp_last_in  = 1'b0;
         if (cw.sum_clr) begin
            sum_in = 8'd0;
            idx_in = '0;
         end else if (cw.sum_add) begin
            sum_in = sum_ff + byte_val;
         end
         if (cw.idx_inc) begin
            idx_in = idx_nxt;
         end
         case (cw.jump)
            ihex_pkg::JMP_NEXT: begin
               step_in = step_ff + 4'd1;
            end
            ihex_pkg::JMP_IF_EMPTY: begin
               step_in = (count_ff == '0) ? cw.target : step_ff + 4'd1;
            end
            ihex_pkg::JMP_IF_MORE: begin
               step_in = (idx_nxt < count_ff) ? cw.target : step_ff + 4'd1;
            end
            ihex_pkg::JMP_END: begin
               if ((type_ff == ihex_pkg::REC_DATA) && (cmd_ff == ihex_pkg::CMD_END)) begin
                  // The flushed data record is out; the end-of-file record follows.
                  count_in = '0;
                  addr_in  = item_addr_ff;
                  type_in  = ihex_pkg::REC_EOF;
                  step_in  = '0;
               end else begin
                  busy_in     = 1'b0;
                  rsp_last_in = 1'b1;
                  if (type_ff == ihex_pkg::REC_DATA) begin
                     // The byte that closed the record starts the next run.
                     count_in = ONE_COUNT;
                     addr_in  = item_addr_ff;
                     wr_en    = 1'b1;
                     wr_addr  = '0;
                     wr_data  = item_data_ff;
                  end
               end
            end
            default: begin
               step_in = step_ff + 4'd1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         record_buffer[wr_addr] <= wr_data;
      end
      rd_ff <= record_buffer[idx_in[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff    <= 5'd16;
         count_ff     <= '0;
         addr_ff      <= 16'd0;
         busy_ff      <= 1'b0;
         step_ff      <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            length_ff <= csr_record_length;
         end
         count_ff     <= count_in;
         addr_ff      <= addr_in;
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sum_ff       <= sum_in;
      type_ff      <= type_in;
      cmd_ff       <= cmd_in;
      item_addr_ff <= item_addr_in;
      item_data_ff <= item_data_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_last_ff  <= rsp_last_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_COUNT)
      else $error("record count exceeds buffer depth");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> step_ff <= ihex_pkg::STEP_LAST)
      else $error("sequencer step outside the program");

   a_data_index: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && step_ff == ihex_pkg::STEP_DATA_HI) |-> idx_ff < count_ff)
      else $error("data step reads beyond the buffered bytes");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (fire && rsp_last_in) |=> (!busy_ff && rsp_valid_ff && rsp_last_ff))
      else $error("final character did not release the sequencer");

endmodule
